>>> hdl/shc_pkg.sv
// ----------------------------------------------------------------------------
// shc_pkg
// Shared types, widths and helpers for the strip hit clusterer.
// ----------------------------------------------------------------------------
package shc_pkg;

	localparam int NUM_LAYERS = 8;
	localparam int POS_BITS   = 10;
	localparam int COUNT_BITS = 12;
	localparam int SUM_BITS   = POS_BITS + COUNT_BITS;
	localparam int LAYER_W    = 4;
	localparam int IDX_W      = (NUM_LAYERS > 1) ? $clog2(NUM_LAYERS) : 1;

	typedef enum logic {
		KIND_HIT       = 1'b0,
		KIND_EVENT_END = 1'b1
	} kind_t;

	typedef logic [LAYER_W-1:0]    layer_t;
	typedef logic [POS_BITS-1:0]   pos_t;
	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [SUM_BITS-1:0]   sum_t;
	typedef logic [IDX_W-1:0]      idx_t;

	typedef struct packed {
		kind_t  kind;
		layer_t layer;
		pos_t   position;
	} item_t;

	typedef struct packed {
		logic   cluster_valid;
		layer_t cluster_layer;
		pos_t   first_position;
		pos_t   last_position;
		count_t hit_count;
		sum_t   position_sum;
		count_t layer_multiplicity;
		count_t cluster_total;
		logic   event_end;
	} result_t;

	function automatic count_t sat_inc(input count_t v);
		count_t r;
		r = (v == {COUNT_BITS{1'b1}}) ? v : v + count_t'(1);
		return r;
	endfunction

	function automatic sum_t sat_add(input sum_t s, input pos_t p);
		logic [SUM_BITS:0] t;
		t = {1'b0, s} + (SUM_BITS+1)'(p);
		return t[SUM_BITS] ? {SUM_BITS{1'b1}} : t[SUM_BITS-1:0];
	endfunction

endpackage

>>> hdl/shc_core.sv
// ----------------------------------------------------------------------------
// shc_core
// Open-cluster state, per-layer counters and result formation for one item.
// ----------------------------------------------------------------------------
module shc_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  shc_pkg::item_t   item,
	output logic             has_result,
	output shc_pkg::result_t result
);
	import shc_pkg::*;

	logic   open_q;
	layer_t last_layer_q;
	pos_t   last_pos_q;
	pos_t   start_pos_q;
	count_t open_count_q;
	sum_t   open_sum_q;
	count_t per_layer_q [NUM_LAYERS];
	count_t event_clusters_q;

	logic   in_range;
	logic   adjacent;
	logic   cont;
	logic   is_end;
	idx_t   idx;
	count_t lay_inc;
	count_t tot_inc;

	assign is_end   = (item.kind == KIND_EVENT_END);
	assign in_range = (item.layer != '0) && (item.layer <= layer_t'(NUM_LAYERS));
	assign adjacent = (item.position == last_pos_q) ||
		({1'b0, item.position} == ({1'b0, last_pos_q} + (POS_BITS+1)'(1)));
	assign cont     = open_q && (item.layer == last_layer_q) && adjacent;
	assign idx      = idx_t'(last_layer_q - layer_t'(1));
	assign lay_inc  = sat_inc(per_layer_q[idx]);
	assign tot_inc  = sat_inc(event_clusters_q);

	assign has_result = is_end || (in_range && open_q && !cont);

	always_comb begin
		result = '0;
		if (open_q) begin
			result.cluster_valid      = 1'b1;
			result.cluster_layer      = last_layer_q;
			result.first_position     = start_pos_q;
			result.last_position      = last_pos_q;
			result.hit_count          = open_count_q;
			result.position_sum       = open_sum_q;
			result.layer_multiplicity = lay_inc;
			result.cluster_total      = tot_inc;
		end
		result.event_end = is_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q           <= 1'b0;
			last_layer_q     <= '0;
			last_pos_q       <= '0;
			start_pos_q      <= '0;
			open_count_q     <= '0;
			open_sum_q       <= '0;
			event_clusters_q <= '0;
			for (int i = 0; i < NUM_LAYERS; i++) begin
				per_layer_q[i] <= '0;
			end
		end else if (step) begin
			if (is_end) begin
				open_q           <= 1'b0;
				last_layer_q     <= '0;
				last_pos_q       <= '0;
				start_pos_q      <= '0;
				open_count_q     <= '0;
				open_sum_q       <= '0;
				event_clusters_q <= '0;
				for (int i = 0; i < NUM_LAYERS; i++) begin
					per_layer_q[i] <= '0;
				end
			end else if (in_range) begin
				if (cont) begin
					last_pos_q   <= item.position;
					open_count_q <= sat_inc(open_count_q);
					open_sum_q   <= sat_add(open_sum_q, item.position);
				end else begin
					if (open_q) begin
						per_layer_q[idx] <= lay_inc;
						event_clusters_q <= tot_inc;
					end
					open_q       <= 1'b1;
					last_layer_q <= item.layer;
					last_pos_q   <= item.position;
					start_pos_q  <= item.position;
					open_count_q <= count_t'(1);
					open_sum_q   <= sum_t'(item.position);
				end
			end
		end
	end

endmodule

>>> hdl/strip_hit_clusterer.sv
// ----------------------------------------------------------------------------
// strip_hit_clusterer
// Groups adjacent tube hits on one layer into clusters and reports each
// closed cluster with its extent, hit count, position sum and multiplicities.
// ----------------------------------------------------------------------------
// One item is taken every clock cycle while in_stall is low. An item waits in
// the input register, where the cluster state is compared and updated, and
// its result, if any, is then captured in the output register. A hit that
// only opens or extends a cluster passes even while the output register
// holds a result.
module strip_hit_clusterer (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    kind,
	input  logic [3:0]              layer,
	input  logic [9:0]              position,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic                    cluster_valid,
	output logic [3:0]              cluster_layer,
	output logic [9:0]              first_position,
	output logic [9:0]              last_position,
	output logic [11:0]             hit_count,
	output logic [21:0]             position_sum,
	output logic [11:0]             layer_multiplicity,
	output logic [11:0]             cluster_total,
	output logic                    event_end
);
	import shc_pkg::*;

	logic    valid_s1;
	item_t   item_s1;
	logic    out_valid_q;
	result_t res_q;

	logic    has_result;
	result_t result;
	logic    out_free;
	logic    advance;
	logic    load;

	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && (!has_result || out_free);
	assign in_stall = valid_s1 && !advance;
	assign load     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1.kind     <= kind_t'(kind);
			item_s1.layer    <= layer;
			item_s1.position <= position;
		end
	end

	shc_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.item       (item_s1),
		.has_result (has_result),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && has_result) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			res_q <= result;
		end
	end

	assign out_valid          = out_valid_q;
	assign cluster_valid      = res_q.cluster_valid;
	assign cluster_layer      = res_q.cluster_layer;
	assign first_position     = res_q.first_position;
	assign last_position      = res_q.last_position;
	assign hit_count          = res_q.hit_count;
	assign position_sum       = res_q.position_sum;
	assign layer_multiplicity = res_q.layer_multiplicity;
	assign cluster_total      = res_q.cluster_total;
	assign event_end          = res_q.event_end;

endmodule
